@@ hdl/gravity_vector_tilt_angles_macros.svh @@
// Assertion helpers for the tilt angle block.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef GRAVITY_VECTOR_TILT_ANGLES_MACROS_SVH
`define GRAVITY_VECTOR_TILT_ANGLES_MACROS_SVH

`ifndef SYNTHESIS

`define GVTA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define GVTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define GVTA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define GVTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/gvta_pkg.sv @@
package gvta_pkg;

    localparam int GVTA_STAGES       = 16;
    localparam int GVTA_TABLE_STAGES = 24;

    localparam int TAG_W  = 6;
    localparam int GRAV_W = 16;
    localparam int CDEG_W = 16;
    localparam int ANG_W  = 32;
    // 2^29 magnitude after scaling, CORDIC gain and sqrt(2) stay below 2^31
    localparam int VEC_W  = 33;
    localparam int SCALE_SH = 14;

    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [CDEG_W-1:0] CDEG_TURN   = 16'd36000;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [ANG_W-1:0] GVTA_ATAN [GVTA_TABLE_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [TAG_W-1:0]         sensor_tag;
        logic signed [GRAV_W-1:0] grav_x;
        logic signed [GRAV_W-1:0] grav_y;
        logic signed [GRAV_W-1:0] grav_z;
    } t_gvta_in;

    typedef struct packed {
        logic [TAG_W-1:0]  tag_out;
        logic [CDEG_W-1:0] pitch_centideg;
        logic [CDEG_W-1:0] roll_centideg;
    } t_gvta_out;

    typedef struct packed {
        logic signed [VEC_W-1:0] a;
        logic signed [VEC_W-1:0] b;
        logic [ANG_W-1:0]        ang;
        logic                    zero;
    } t_gvta_vec;

    // scale and fold the vector into the right half plane
    function automatic t_gvta_vec gvta_init_vec(logic signed [GRAV_W-1:0] a_in,
                                                logic signed [GRAV_W-1:0] b_in);
        t_gvta_vec               v;
        logic signed [VEC_W-1:0] a_s;
        logic signed [VEC_W-1:0] b_s;
        a_s = {{(VEC_W-GRAV_W-SCALE_SH){a_in[GRAV_W-1]}}, a_in, {SCALE_SH{1'b0}}};
        b_s = {{(VEC_W-GRAV_W-SCALE_SH){b_in[GRAV_W-1]}}, b_in, {SCALE_SH{1'b0}}};
        v.zero = (a_in == '0) && (b_in == '0);
        if (a_s[VEC_W-1]) begin
            v.a   = -a_s;
            v.b   = -b_s;
            v.ang = HALF_TURN;
        end else begin
            v.a   = a_s;
            v.b   = b_s;
            v.ang = '0;
        end
        return v;
    endfunction

endpackage

@@ hdl/gvta_cell.sv @@
module gvta_cell #(
    parameter int                           SHIFT     = 0,
    parameter logic [gvta_pkg::ANG_W-1:0]   ATAN_STEP = '0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  gvta_pkg::t_gvta_vec i_vec,
    output gvta_pkg::t_gvta_vec o_vec
);
    import gvta_pkg::*;

    t_gvta_vec               r_vec;
    t_gvta_vec               n_vec;
    logic signed [VEC_W-1:0] da;
    logic signed [VEC_W-1:0] db;

    always_comb begin
        da    = i_vec.b >>> SHIFT;
        db    = i_vec.a >>> SHIFT;
        n_vec = i_vec;
        // rotate toward the x axis, direction set by the sign of b
        if (!i_vec.b[VEC_W-1]) begin
            n_vec.a   = i_vec.a + da;
            n_vec.b   = i_vec.b - db;
            n_vec.ang = i_vec.ang + ATAN_STEP;
        end else begin
            n_vec.a   = i_vec.a - da;
            n_vec.b   = i_vec.b + db;
            n_vec.ang = i_vec.ang - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

@@ hdl/gvta_scale.sv @@
module gvta_scale (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [gvta_pkg::ANG_W-1:0]    i_ang,
    input  logic                          i_zero,
    output logic [gvta_pkg::CDEG_W-1:0]   o_centideg
);
    import gvta_pkg::*;

    localparam int PROD_W = ANG_W + CDEG_W;

    logic [ANG_W-1:0]  ang_adj;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] sum;
    logic [CDEG_W-1:0] r_cdeg;
    logic [CDEG_W-1:0] n_cdeg;

    // minus a quarter turn; wraps mod 2^32 like the +360 fold
    assign ang_adj = (i_zero ? '0 : i_ang) - QUARTER_TURN;
    assign n_prod  = PROD_W'(ang_adj) * PROD_W'(CDEG_TURN);

    always_comb begin
        sum    = r_prod + PROD_W'(HALF_TURN);
        n_cdeg = sum[PROD_W-1:ANG_W];
        if (n_cdeg >= CDEG_TURN) begin
            n_cdeg = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_cdeg <= n_cdeg;
        end
    end

    assign o_centideg = r_cdeg;

endmodule

@@ hdl/gravity_vector_tilt_angles.sv @@
// Throughput: one request per cycle while o_stall is low; an input register scales and folds
// each vector, then a row of CORDIC cells, one rotation per cell, then a multiply stage and a
// rounding stage per angle, then the output register.
// A skid register behind the output holds one result when o_valid is stalled.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
`include "gravity_vector_tilt_angles_macros.svh"

module gravity_vector_tilt_angles #(
    parameter int CORDIC_STAGES = gvta_pkg::GVTA_STAGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gvta_pkg::t_gvta_in  i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output gvta_pkg::t_gvta_out o_rsp
);
    import gvta_pkg::*;

    localparam int DEPTH = CORDIC_STAGES + 3;

    logic             en;
    logic             r_vld [DEPTH];
    logic [TAG_W-1:0] r_tag [DEPTH];

    t_gvta_vec pitch_vec [CORDIC_STAGES+1];
    t_gvta_vec roll_vec  [CORDIC_STAGES+1];
    t_gvta_vec r_pitch0;
    t_gvta_vec r_roll0;

    logic [CDEG_W-1:0] pitch_cdeg;
    logic [CDEG_W-1:0] roll_cdeg;
    t_gvta_out         p_rsp;
    logic              p_vld;

    t_gvta_out r_out;
    logic      r_out_v;
    t_gvta_out r_skid;
    logic      r_skid_v;
    logic      out_free;

    // whole row moves together; frozen only while the skid holds a result
    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= i_req.sensor_tag;
            for (int k = 1; k < DEPTH; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r_pitch0 <= gvta_init_vec(i_req.grav_y, i_req.grav_z);
            r_roll0  <= gvta_init_vec(i_req.grav_x, i_req.grav_z);
        end
    end

    assign pitch_vec[0] = r_pitch0;
    assign roll_vec[0]  = r_roll0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cells
        gvta_cell #(
            .SHIFT     (g),
            .ATAN_STEP (GVTA_ATAN[g])
        ) u_pitch_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (pitch_vec[g]),
            .o_vec (pitch_vec[g+1])
        );
        gvta_cell #(
            .SHIFT     (g),
            .ATAN_STEP (GVTA_ATAN[g])
        ) u_roll_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (roll_vec[g]),
            .o_vec (roll_vec[g+1])
        );
    end

    gvta_scale u_pitch_scale (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_ang      (pitch_vec[CORDIC_STAGES].ang),
        .i_zero     (pitch_vec[CORDIC_STAGES].zero),
        .o_centideg (pitch_cdeg)
    );

    gvta_scale u_roll_scale (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_ang      (roll_vec[CORDIC_STAGES].ang),
        .i_zero     (roll_vec[CORDIC_STAGES].zero),
        .o_centideg (roll_cdeg)
    );

    assign p_vld                = r_vld[DEPTH-1];
    assign p_rsp.tag_out        = r_tag[DEPTH-1];
    assign p_rsp.pitch_centideg = pitch_cdeg;
    assign p_rsp.roll_centideg  = roll_cdeg;

    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= p_vld;
            end
        end else if (p_vld) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : p_rsp;
        end else if (en) begin
            r_skid <= p_rsp;
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

    `GVTA_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `GVTA_ASSERT_NEXT(a_held_goes_skid, i_clk, i_rst_n, !out_free && p_vld, r_skid_v)
    `GVTA_ASSERT_SAME(a_pitch_range, i_clk, i_rst_n, o_valid, o_rsp.pitch_centideg < CDEG_TURN)
    `GVTA_ASSERT_SAME(a_roll_range, i_clk, i_rst_n, o_valid, o_rsp.roll_centideg < CDEG_TURN)

endmodule

@@ sim/gvta_checker.sv @@
`timescale 1ns / 100ps

module gvta_checker #(
    parameter int STAGES = gvta_pkg::GVTA_STAGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  gvta_pkg::t_gvta_in  i_req,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_stall,
    input  gvta_pkg::t_gvta_out i_rsp,
    output int                  o_errors,
    output int                  o_pending
);
    import gvta_pkg::*;

    // atan(2^-i) in binary-angle units, 2^32 per turn
    localparam logic [31:0] ATAN_STEP [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    t_gvta_out tilt_q[$];
    int        err_cnt = 0;

    assign o_errors = err_cnt;

    // binary angle of atan2(b, a); zero vector gives zero
    function automatic logic [31:0] vector_angle(logic signed [15:0] a_in,
                                                 logic signed [15:0] b_in);
        longint      a;
        longint      b;
        longint      da;
        longint      db;
        logic [31:0] ang;
        if (a_in == '0 && b_in == '0) begin
            return '0;
        end
        a   = longint'(a_in) * 16384;
        b   = longint'(b_in) * 16384;
        ang = '0;
        if (a < 0) begin
            a   = -a;
            b   = -b;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a   = a + da;
                b   = b - db;
                ang = ang + ATAN_STEP[i];
            end else begin
                a   = a - da;
                b   = b + db;
                ang = ang - ATAN_STEP[i];
            end
        end
        return ang;
    endfunction

    // angle minus a quarter turn, in rounded centidegrees
    function automatic logic [15:0] tilt_cdeg(logic signed [15:0] a_in,
                                              logic signed [15:0] b_in);
        logic [31:0] ang;
        logic [63:0] c;
        ang = vector_angle(a_in, b_in) - 32'h4000_0000;
        c   = ({32'd0, ang} * 64'd36000 + 64'h8000_0000) >> 32;
        if (c >= 64'd36000) begin
            c = '0;
        end
        return c[15:0];
    endfunction

    function automatic t_gvta_out predict_tilt(t_gvta_in r);
        t_gvta_out e;
        e.tag_out        = r.sensor_tag;
        e.pitch_centideg = tilt_cdeg(r.grav_y, r.grav_z);
        e.roll_centideg  = tilt_cdeg(r.grav_x, r.grav_z);
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_gvta_out want;
        if (!i_rst_n) begin
            tilt_q.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (tilt_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, ", $time,
                             "got tag=%0d pitch=%0d roll=%0d", i_rsp.tag_out,
                             i_rsp.pitch_centideg, i_rsp.roll_centideg);
                end else begin
                    want = tilt_q.pop_front();
                    if (want.tag_out !== i_rsp.tag_out
                            || want.pitch_centideg !== i_rsp.pitch_centideg
                            || want.roll_centideg !== i_rsp.roll_centideg) begin
                        err_cnt++;
                        $display("%0t: mismatch, ", $time,
                                 "expected tag=%0d pitch=%0d roll=%0d, ", want.tag_out,
                                 want.pitch_centideg, want.roll_centideg,
                                 "got tag=%0d pitch=%0d roll=%0d", i_rsp.tag_out,
                                 i_rsp.pitch_centideg, i_rsp.roll_centideg);
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                tilt_q.push_back(predict_tilt(i_req));
            end
        end
        o_pending <= tilt_q.size();
    end

endmodule

@@ sim/tb_gravity_vector_tilt_angles.sv @@
`timescale 1ns / 100ps

module tb_gravity_vector_tilt_angles;
    import gvta_pkg::*;

    localparam int LATENCY    = GVTA_STAGES + 3;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYC   = 80;
    localparam int PHASE_REQS = 125;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      req_vld = 1'b0;
    logic      req_stl;
    t_gvta_in  req     = '0;
    logic      rsp_vld;
    logic      rsp_stl = 1'b0;
    t_gvta_out rsp;

    int        errors;
    int        pending;
    int        idle_pct  = 0;
    int        stall_pct = 0;
    logic      hold_req  = 1'b0;
    int        hold_left = 0;
    int        quiet_cyc = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gravity_vector_tilt_angles DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_vld),
        .o_stall (req_stl),
        .i_req   (req),
        .o_valid (rsp_vld),
        .i_stall (rsp_stl),
        .o_rsp   (rsp)
    );

    gvta_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_vld),
        .i_req_stall (req_stl),
        .i_req       (req),
        .i_rsp_valid (rsp_vld),
        .i_rsp_stall (rsp_stl),
        .i_rsp       (rsp),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYC;
            rsp_stl   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stl   <= 1'b1;
        end else begin
            rsp_stl <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_vld && !req_stl) || (rsp_vld && !rsp_stl)) begin
                quiet_cyc <= 0;
            end else if (quiet_cyc >= IDLE_LIMIT) begin
                $display("FAIL gravity_vector_tilt_angles");
                $finish;
            end else begin
                quiet_cyc <= quiet_cyc + 1;
            end
        end
    end

    task automatic send_tilt_req(t_gvta_in r);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_vld <= 1'b0;
            @(posedge clk);
        end
        req_vld <= 1'b1;
        req     <= r;
        do @(posedge clk); while (req_stl);
    endtask

    task automatic send_vec(int tag, int x, int y, int z);
        t_gvta_in r;
        r.sensor_tag = 6'(tag);
        r.grav_x     = 16'(x);
        r.grav_y     = 16'(y);
        r.grav_z     = 16'(z);
        send_tilt_req(r);
    endtask

    task automatic wait_drained();
        req_vld <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mix of full-range, tiny, zero and extreme axis values
    function automatic logic [15:0] rand_axis();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0, 1, 2: v = 16'($urandom);
            3:       v = 16'(int'($urandom_range(0, 8)) - 4);
            4:       v = '0;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'hffff;
                    default: v = 16'h0001;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        t_gvta_in r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_vec(0, 0, 0, 0);                   // zero vector on both angles
        send_vec(63, 32767, 32767, 32767);
        send_vec(21, -32768, -32768, -32768);
        send_vec(42, 32767, -32768, 0);
        send_vec(1, 1, 1, 32767);               // rounds up to a full turn
        send_vec(2, -1, -1, 32767);
        send_vec(3, 0, 0, 1);
        send_vec(4, 0, 0, -1);
        send_vec(5, 1, 1, 0);
        send_vec(6, -1, -1, 0);
        send_vec(7, 32767, -32768, -1);
        send_vec(8, -32768, 32767, 1);
        send_vec(9, 0, 5, 0);
        send_vec(10, -5, 0, 0);
        send_vec(11, 1, -1, -32768);
        send_vec(12, 100, -100, -1);
        send_vec(13, 12345, -23456, 7890);
        send_vec(14, 16'h5555, 16'haaaa, 16'h5555);
        send_vec(49, 16'haaaa, 16'h5555, 16'haaaa);
        send_vec(50, -32768, 0, -32768);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 61; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 7;  stall_pct = 7;  end
            endcase
            // long receiver hold-off while requests keep coming
            if (ph == 0) begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            for (int n = 0; n < PHASE_REQS; n++) begin
                r.sensor_tag = 6'($urandom);
                r.grav_x     = rand_axis();
                r.grav_y     = rand_axis();
                r.grav_z     = rand_axis();
                send_tilt_req(r);
            end
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0) begin
            $display("PASS gravity_vector_tilt_angles");
        end else begin
            $display("FAIL gravity_vector_tilt_angles");
        end
        $finish;
    end

endmodule
